/* design/source_text_tokenizer_defines.svh */
// Assertion macros shared by the tokenizer RTL.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define STT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define STT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define STT_ASSERT(lbl, prop, msg)
`define STT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* design/stt_pkg.sv */
// Shared types, codes and character classes of the source text tokenizer.
`timescale 1ns / 1ps
`default_nettype none
package stt_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam logic [FIELD_W-1:0] FIELD_MAX = 16'hFFFF;

    localparam int MODE_W = 5;
    localparam logic [MODE_W-1:0] MODE_IDLE    = 5'd0;
    localparam logic [MODE_W-1:0] MODE_COMMENT = 5'd1;
    localparam logic [MODE_W-1:0] MODE_NAME    = 5'd2;
    localparam logic [MODE_W-1:0] MODE_HASH    = 5'd3;
    localparam logic [MODE_W-1:0] MODE_INT     = 5'd4;
    localparam logic [MODE_W-1:0] MODE_NUM     = 5'd5;
    localparam logic [MODE_W-1:0] MODE_NUM_DOT = 5'd6;
    localparam logic [MODE_W-1:0] MODE_FRAC    = 5'd7;
    localparam logic [MODE_W-1:0] MODE_STR     = 5'd8;
    localparam logic [MODE_W-1:0] MODE_STR_ESC = 5'd9;
    localparam logic [MODE_W-1:0] MODE_QUOTE   = 5'd10;
    localparam logic [MODE_W-1:0] MODE_SYM     = 5'd11;
    localparam logic [MODE_W-1:0] MODE_AT      = 5'd12;
    localparam logic [MODE_W-1:0] MODE_DIR     = 5'd13;
    localparam logic [MODE_W-1:0] MODE_COLON   = 5'd14;
    localparam logic [MODE_W-1:0] MODE_BAR1    = 5'd15;
    localparam logic [MODE_W-1:0] MODE_OPER    = 5'd16;

    localparam logic [4:0] KIND_EOF      = 5'd0;
    localparam logic [4:0] KIND_ERROR    = 5'd1;
    localparam logic [4:0] KIND_NAME     = 5'd2;
    localparam logic [4:0] KIND_INTEGER  = 5'd3;
    localparam logic [4:0] KIND_FLOAT    = 5'd4;
    localparam logic [4:0] KIND_STRING   = 5'd5;
    localparam logic [4:0] KIND_SYMBOL   = 5'd6;
    localparam logic [4:0] KIND_DIRECT   = 5'd7;
    localparam logic [4:0] KIND_OPERATOR = 5'd8;
    localparam logic [4:0] KIND_ASSIGN   = 5'd9;
    localparam logic [4:0] KIND_COLON    = 5'd10;
    localparam logic [4:0] KIND_DOT      = 5'd11;
    localparam logic [4:0] KIND_COMMA    = 5'd12;
    localparam logic [4:0] KIND_BAR      = 5'd13;
    localparam logic [4:0] KIND_LPAREN   = 5'd14;
    localparam logic [4:0] KIND_RPAREN   = 5'd15;
    localparam logic [4:0] KIND_LBRACKET = 5'd16;
    localparam logic [4:0] KIND_RBRACKET = 5'd17;
    localparam logic [4:0] KIND_LBRACE   = 5'd18;
    localparam logic [4:0] KIND_RBRACE   = 5'd19;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_HASH       = 3'd1;
    localparam logic [2:0] ERR_UNCLOSED   = 3'd2;
    localparam logic [2:0] ERR_SYMBOL     = 3'd3;
    localparam logic [2:0] ERR_DIRECTIVE  = 3'd4;
    localparam logic [2:0] ERR_STRAY      = 3'd5;

    // One finished token as it leaves the block.
    typedef struct packed {
        logic [4:0]         kind;
        logic [FIELD_W-1:0] offset;
        logic [FIELD_W-1:0] length;
        logic [2:0]         err;
    } res_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_letter(c) || is_numeral(c);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic logic is_opchar(input logic [7:0] c);
        logic hit;
        hit = 1'b0;
        case (c) inside
            "+", "-", "*", "/", "<", ">", "=", "!", "&", "^", "%", "~", "?",
            "\\": hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage
`default_nettype wire

/* design/stt_lex.sv */
// Next-state and token logic for one source byte of the tokenizer.
`timescale 1ns / 1ps
`default_nettype none
module stt_lex
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic [7:0]             c,
    input  wire logic [MODE_W-1:0]      mode,
    input  wire logic [OFFSET_BITS-1:0] start,
    input  wire logic [OFFSET_BITS-1:0] pos,
    input  wire logic [OFFSET_BITS-1:0] dot,
    output logic      [MODE_W-1:0]      mode_next,
    output logic      [OFFSET_BITS-1:0] start_next,
    output logic      [OFFSET_BITS-1:0] pos_next,
    output logic      [OFFSET_BITS-1:0] dot_next,
    output logic      [1:0]             tok_cnt,
    output res_t                        toks [3]
);

    localparam int XW = (OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W;
    localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;

    typedef struct packed {
        logic [4:0]             kind;
        logic [OFFSET_BITS-1:0] first;
        logic [OFFSET_BITS-1:0] stop;
        logic [2:0]             err;
    } raw_tok_t;

    function automatic logic [OFFSET_BITS-1:0] sat_next(input logic [OFFSET_BITS-1:0] v);
        return (v == OFS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [FIELD_W-1:0] sat_field(input logic [OFFSET_BITS-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        return (x > XW'(FIELD_MAX)) ? FIELD_MAX : x[FIELD_W-1:0];
    endfunction

    function automatic res_t finish(input raw_tok_t t);
        res_t r;
        r.kind   = t.kind;
        r.offset = sat_field(t.first);
        r.length = sat_field((t.stop > t.first) ? t.stop - t.first : '0);
        r.err    = t.err;
        return r;
    endfunction

    function automatic raw_tok_t mk(input logic [4:0] k, input logic [OFFSET_BITS-1:0] a,
                                    input logic [OFFSET_BITS-1:0] b, input logic [2:0] e);
        raw_tok_t t;
        t.kind  = k;
        t.first = a;
        t.stop  = b;
        t.err   = e;
        return t;
    endfunction

    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] start_inc;
    logic                   again;
    logic                   pv0;
    logic                   pv1;
    logic                   iv;
    logic [MODE_W-1:0]      mode_a;
    logic [MODE_W-1:0]      mode_i;
    logic [4:0]             punct_kind;
    raw_tok_t               pt0;
    raw_tok_t               pt1;
    raw_tok_t               it;

    assign pos_inc   = sat_next(pos);
    assign start_inc = sat_next(start);

    // Finish whatever token the current mode holds.
    always_comb begin
        again    = 1'b0;
        pv0      = 1'b0;
        pv1      = 1'b0;
        mode_a   = mode;
        dot_next = dot;
        pt0      = mk(KIND_ERROR, start, pos, ERR_NONE);
        pt1      = mk(KIND_DOT, dot, sat_next(dot), ERR_NONE);
        unique case (mode)
            MODE_IDLE: again = 1'b1;
            MODE_COMMENT: begin
                if (c == 8'h0A) begin
                    mode_a = MODE_IDLE;
                end else if (c == 8'h00) begin
                    again = 1'b1;
                end
            end
            MODE_NAME: begin
                if (!is_word(c)) begin
                    pv0 = 1'b1; again = 1'b1;
                    pt0 = mk(KIND_NAME, start, pos, ERR_NONE);
                end
            end
            MODE_HASH: begin
                if (is_numeral(c)) begin
                    mode_a = MODE_INT;
                end else begin
                    pv0 = 1'b1; again = 1'b1;
                    pt0 = mk(KIND_ERROR, start, start_inc, ERR_HASH);
                end
            end
            MODE_INT: begin
                if (!is_numeral(c)) begin
                    pv0 = 1'b1; again = 1'b1;
                    pt0 = mk(KIND_INTEGER, start, pos, ERR_NONE);
                end
            end
            MODE_NUM: begin
                if (c == ".") begin
                    dot_next = pos;
                    mode_a   = MODE_NUM_DOT;
                end else if (!is_numeral(c)) begin
                    pv0 = 1'b1; again = 1'b1;
                    pt0 = mk(KIND_FLOAT, start, pos, ERR_NONE);
                end
            end
            MODE_NUM_DOT: begin
                if (is_numeral(c)) begin
                    mode_a = MODE_FRAC;
                end else begin
                    // The dot did not start a fraction: float, then a dot token.
                    pv0 = 1'b1; pv1 = 1'b1; again = 1'b1;
                    pt0 = mk(KIND_FLOAT, start, dot, ERR_NONE);
                end
            end
            MODE_FRAC: begin
                if (!is_numeral(c)) begin
                    pv0 = 1'b1; again = 1'b1;
                    pt0 = mk(KIND_FLOAT, start, pos, ERR_NONE);
                end
            end
            MODE_STR: begin
                if (c == "\"") begin
                    pv0    = 1'b1;
                    mode_a = MODE_IDLE;
                    pt0    = mk(KIND_STRING, start, pos_inc, ERR_NONE);
                end else if (c == "\\") begin
                    mode_a = MODE_STR_ESC;
                end else if (c == 8'h00) begin
                    pv0 = 1'b1; again = 1'b1;
                    pt0 = mk(KIND_ERROR, start, pos, ERR_UNCLOSED);
                end
            end
            MODE_STR_ESC: begin
                if (c == 8'h00) begin
                    pv0 = 1'b1; again = 1'b1;
                    pt0 = mk(KIND_ERROR, start, pos, ERR_UNCLOSED);
                end else begin
                    mode_a = MODE_STR;
                end
            end
            MODE_QUOTE: begin
                if (is_letter(c)) begin
                    mode_a = MODE_SYM;
                end else begin
                    pv0 = 1'b1; again = 1'b1;
                    pt0 = mk(KIND_ERROR, start, start_inc, ERR_SYMBOL);
                end
            end
            MODE_SYM: begin
                if (!is_word(c)) begin
                    pv0 = 1'b1; again = 1'b1;
                    pt0 = mk(KIND_SYMBOL, start, pos, ERR_NONE);
                end
            end
            MODE_AT: begin
                if (is_letter(c)) begin
                    mode_a = MODE_DIR;
                end else begin
                    pv0 = 1'b1; again = 1'b1;
                    pt0 = mk(KIND_ERROR, start, start_inc, ERR_DIRECTIVE);
                end
            end
            MODE_DIR: begin
                if (!is_word(c)) begin
                    pv0 = 1'b1; again = 1'b1;
                    pt0 = mk(KIND_DIRECT, start, pos, ERR_NONE);
                end
            end
            MODE_COLON: begin
                pv0 = 1'b1;
                if (c == "=") begin
                    mode_a = MODE_IDLE;
                    pt0    = mk(KIND_ASSIGN, start, pos_inc, ERR_NONE);
                end else begin
                    again = 1'b1;
                    pt0   = mk(KIND_COLON, start, pos, ERR_NONE);
                end
            end
            MODE_BAR1: begin
                if (c == "|") begin
                    mode_a = MODE_OPER;
                end else begin
                    pv0 = 1'b1; again = 1'b1;
                    pt0 = mk(KIND_BAR, start, pos, ERR_NONE);
                end
            end
            MODE_OPER: begin
                if (!is_opchar(c)) begin
                    pv0 = 1'b1; again = 1'b1;
                    pt0 = mk(KIND_OPERATOR, start, pos, ERR_NONE);
                end
            end
            default: again = 1'b1;
        endcase
    end

    always_comb begin
        punct_kind = KIND_EOF;
        case (c)
            ".":     punct_kind = KIND_DOT;
            ",":     punct_kind = KIND_COMMA;
            "(":     punct_kind = KIND_LPAREN;
            ")":     punct_kind = KIND_RPAREN;
            "[":     punct_kind = KIND_LBRACKET;
            "]":     punct_kind = KIND_RBRACKET;
            "{":     punct_kind = KIND_LBRACE;
            "}":     punct_kind = KIND_RBRACE;
            default: punct_kind = KIND_EOF;
        endcase
    end

    // Treat the byte as the first byte of a new token.
    always_comb begin
        iv     = 1'b0;
        mode_i = MODE_IDLE;
        it     = mk(KIND_EOF, pos, pos, ERR_NONE);
        if (is_blank(c)) begin
            mode_i = MODE_IDLE;
        end else if (c == ";") begin
            mode_i = MODE_COMMENT;
        end else if (c == 8'h00) begin
            iv = 1'b1;
        end else if (is_letter(c)) begin
            mode_i = MODE_NAME;
        end else if (is_numeral(c)) begin
            mode_i = MODE_NUM;
        end else if (c == "#") begin
            mode_i = MODE_HASH;
        end else if (c == "\"") begin
            mode_i = MODE_STR;
        end else if (c == "'") begin
            mode_i = MODE_QUOTE;
        end else if (c == "@") begin
            mode_i = MODE_AT;
        end else if (c == ":") begin
            mode_i = MODE_COLON;
        end else if (c == "|") begin
            mode_i = MODE_BAR1;
        end else if (is_opchar(c)) begin
            mode_i = MODE_OPER;
        end else if (punct_kind != KIND_EOF) begin
            iv = 1'b1;
            it = mk(punct_kind, pos, pos_inc, ERR_NONE);
        end else begin
            iv = 1'b1;
            it = mk(KIND_ERROR, pos, pos_inc, ERR_STRAY);
        end
    end

    logic iv_used;
    assign iv_used = again && iv;

    always_comb begin
        mode_next  = again ? mode_i : mode_a;
        start_next = again ? pos : start;
        pos_next   = pos_inc;
        if (c == 8'h00) begin
            // End of text: the next byte begins a new text at offset zero.
            mode_next  = MODE_IDLE;
            start_next = '0;
            pos_next   = '0;
        end
    end

    // Pending tokens come first, the token begun by this byte last.
    assign toks[0] = finish(pv0 ? pt0 : it);
    assign toks[1] = finish(pv1 ? pt1 : it);
    assign toks[2] = finish(it);
    assign tok_cnt = 2'(pv0) + 2'(pv1) + 2'(iv_used);

endmodule
`default_nettype wire

/* design/source_text_tokenizer.sv */
// Top level of the source text tokenizer: input register, lexer state and result queue.
//
//  Channel | Ports            | Payload
//  --------+------------------+----------------------------------------------------
//  input   | s_tvalid/tready  | s_tdata[7:0]: text byte, zero ends the text
//  result  | m_tvalid/tready  | m_tuser: token kind; m_tdata: offset, length, error
//          | m_tlast          | set on the last token caused by one byte
//
// A byte is held in the input register and lexed in a single pass into a
// three-entry result queue, so the block takes one byte per cycle while each
// byte gives at most one token and m_tready is high. A byte giving more tokens
// holds the queue until all have left, since the queue only loads once drained.
// Reset clears the lexer to idle with position and token start at zero.
// A stalled result side fills the input register and then drops s_tready.
`timescale 1ns / 1ps
`default_nettype none
`include "source_text_tokenizer_defines.svh"
module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [15:0] token_offset, [31:16] token_length,
                                        // [34:32] error_code, [39:35] zero
    output logic [4:0]       m_tuser,   // [4:0] token_kind
    output logic             m_tlast    // last_of_run
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [7:0]             in_byte_reg;
    logic [MODE_W-1:0]      mode_reg;
    logic [MODE_W-1:0]      mode_next;
    logic [OFFSET_BITS-1:0] start_reg;
    logic [OFFSET_BITS-1:0] start_next;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic [OFFSET_BITS-1:0] pos_next;
    logic [OFFSET_BITS-1:0] dot_reg;
    logic [OFFSET_BITS-1:0] dot_next;
    logic [1:0]             cnt_reg;
    logic [1:0]             cnt_next;
    res_t                   q_reg [3];
    res_t                   toks  [3];
    logic [1:0]             tok_cnt;
    logic                   q_free;
    logic                   lex_load;
    logic                   s_xfer;
    logic                   m_xfer;

    stt_lex #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_lex (
        .c          (in_byte_reg),
        .mode       (mode_reg),
        .start      (start_reg),
        .pos        (pos_reg),
        .dot        (dot_reg),
        .mode_next  (mode_next),
        .start_next (start_next),
        .pos_next   (pos_next),
        .dot_next   (dot_next),
        .tok_cnt    (tok_cnt),
        .toks       (toks)
    );

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_xfer   = m_tvalid && m_tready;
    // The queue takes a new byte's tokens once its last entry leaves.
    assign q_free   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign lex_load = in_valid_reg && q_free;
    assign s_tready = !in_valid_reg || lex_load;
    assign s_xfer   = s_tvalid && s_tready;

    assign m_tuser = q_reg[0].kind;
    assign m_tdata = {5'd0, q_reg[0].err, q_reg[0].length, q_reg[0].offset};
    assign m_tlast = (cnt_reg == 2'd1);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (lex_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (lex_load) begin
            cnt_next = tok_cnt;
        end else if (m_xfer) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            start_reg    <= '0;
            pos_reg      <= '0;
            dot_reg      <= '0;
            cnt_reg      <= 2'd0;
        end else begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            if (lex_load) begin
                mode_reg  <= mode_next;
                start_reg <= start_next;
                pos_reg   <= pos_next;
                dot_reg   <= dot_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg <= s_tdata;
        end
        if (lex_load) begin
            q_reg[0] <= toks[0];
            q_reg[1] <= toks[1];
            q_reg[2] <= toks[2];
        end else if (m_xfer) begin
            q_reg[0] <= q_reg[1];
            q_reg[1] <= q_reg[2];
        end
    end

    `STT_ASSERT(a_load_shows, lex_load && tok_cnt != 2'd0 |=> m_tvalid, "tokens lost on load")
    `STT_ASSERT(a_eof_rewind, lex_load && in_byte_reg == 8'h00 |=> pos_reg == '0 && start_reg == '0, "end of text did not rewind")
    `STT_ASSERT(a_eof_len, m_tvalid && m_tuser == KIND_EOF |-> m_tdata[31:16] == 16'd0, "eof token with length")
    `STT_ASSERT(a_err_code, m_tvalid |-> ((m_tuser == KIND_ERROR) == (m_tdata[34:32] != ERR_NONE)), "error code and kind disagree")
    `STT_ASSERT_ALWAYS(a_rst_empty, !aresetn |=> !m_tvalid && s_tready, "queue not empty after reset")

endmodule
`default_nettype wire
